// ===== rtl/qxmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_pkg
// Shared widths, constants, types and helpers of the quad X motor mixer.
// ----------------------------------------------------------------------------
package qxmm_pkg;

   localparam int CMD_W   = 32;
   localparam int GAIN_W  = 32;
   localparam int MV_W    = 16;
   localparam int SCALE_W = 16;
   localparam int ARM_W   = 2;
   localparam int DUTY_W  = 16;
   localparam int IDX_W   = 3;

   localparam int REQ_W = 152;   // 147 bits of fields, zero filled to bytes
   localparam int RSP_W = 72;    // 66 bits of fields, zero filled to bytes

   localparam int PROD_W = CMD_W + GAIN_W;   // |cmd| * gain
   localparam int SUM_W  = 51;               // signed sum of four Q.8 terms
   localparam int SQ_W   = 50;               // clamped sum, even bit count
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int ROOT_W = SQRT_STEPS;
   localparam int REM_W  = ROOT_W + 4;
   localparam int D_W    = 23;               // 115*mv + 5948
   localparam int DLIM_W = 41;               // d * Q_SAT
   localparam int WSQ_W  = 2 * ROOT_W;
   localparam int LIN_W  = ROOT_W + 17;
   localparam int N_W    = 52;
   localparam int NUM_W  = 58;
   localparam int DIV_STEPS = 18;
   localparam int REMD_W = 41;
   localparam int Q_W    = DIV_STEPS;
   localparam int P_W    = 19;
   localparam int MUL_W  = P_W + SCALE_W;
   localparam int STOP_W = 26;

   // sign stage, sqrt steps, square/linear, numerator, x100, saturation check,
   // divide steps, pulse clamp, duty product
   localparam int LANE_LAT = 1 + SQRT_STEPS + 3 + 1 + DIV_STEPS + 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [LIN_W-1:0] LIN_K   = LIN_W'(74688);
   localparam logic [N_W-1:0]   CONST_K = N_W'(34176000);
   localparam logic [D_W-1:0]   D_MUL   = D_W'(115);
   localparam logic [D_W-1:0]   D_ADD   = D_W'(5948);
   localparam logic [DLIM_W-1:0] Q_SAT  = DLIM_W'(159719);
   localparam logic [P_W-1:0]   P_OFF   = P_W'(237082);
   localparam logic [P_W-1:0]   P_MIN   = P_W'(268800);
   localparam logic [P_W-1:0]   P_MAX   = P_W'(396800);
   localparam logic [STOP_W-1:0] STOP_US = STOP_W'(950);
   localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

   localparam logic [ARM_W-1:0] ARM_RUN = 2'd2;

   localparam logic [IDX_W-1:0] REG_GAIN_THRUST = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_ROLL   = 3'd1;
   localparam logic [IDX_W-1:0] REG_GAIN_PITCH  = 3'd2;
   localparam logic [IDX_W-1:0] REG_GAIN_YAW    = 3'd3;
   localparam logic [IDX_W-1:0] REG_DUTY_SCALE  = 3'd4;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_thrust;
      logic [GAIN_W-1:0]  gain_roll;
      logic [GAIN_W-1:0]  gain_pitch;
      logic [GAIN_W-1:0]  gain_yaw;
      logic [SCALE_W-1:0] duty_scale;
   } qxmm_cfg_type;

   typedef struct packed {
      logic                    run;
      logic [D_W-1:0]          d;
      logic signed [SUM_W-1:0] s4;
      logic signed [SUM_W-1:0] s3;
      logic signed [SUM_W-1:0] s2;
      logic signed [SUM_W-1:0] s1;
   } qxmm_entry_type;

   function automatic logic [CMD_W-1:0] cmd_mag(input logic [CMD_W-1:0] c);
      return c[CMD_W-1] ? (CMD_W'(0) - c) : c;
   endfunction

   function automatic logic signed [SUM_W-1:0] signed_term(input logic neg,
                                                          input logic [PROD_W-1:0] prod);
      logic [SUM_W-1:0] m;
      m = SUM_W'(prod[PROD_W-1:16]);
      return neg ? -$signed(m) : $signed(m);
   endfunction

endpackage

// ===== rtl/quad_x_motor_mixer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_unit
// Quadrotor X-frame motor mixer: four PWM duties from attitude commands.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | req_tdata  (commands, battery, arming)
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata  (four duties, status bits)
//  csr     | in  | csr_we             | csr_index, csr_wdata
//
// One word per cycle in and out while rsp is not stalled; the square root and
// divide pipelines each give one result bit per stage.
// Reset is synchronous, sets the configuration to its defaults and clears the valid flags.
// A stall on rsp freezes the back pipeline; the queue keeps taking words from
// the front until it fills, then the front register holds one more word and req_tready drops.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [31:0] cmd_thrust, [63:32] cmd_roll, [95:64] cmd_pitch, [127:96] cmd_yaw,
   // [143:128] battery_mv, [145:144] arm_state, [146] turn_off
   input  logic [qxmm_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [15:0] duty_m1, [31:16] duty_m2, [47:32] duty_m3, [63:48] duty_m4,
   // [64] motors_running, [65] clear_integrals
   output logic [qxmm_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_we,
   input  logic [qxmm_pkg::IDX_W-1:0]  csr_index,
   input  logic [qxmm_pkg::GAIN_W-1:0] csr_wdata
);
   import qxmm_pkg::*;

   qxmm_cfg_type   cfg_ff;
   qxmm_entry_type push_entry, pop_entry;
   logic           push_valid, push_ready, pop_valid, pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_thrust <= GAIN_W'(31387935);
         cfg_ff.gain_roll   <= '0;
         cfg_ff.gain_pitch  <= '0;
         cfg_ff.gain_yaw    <= GAIN_W'(13932093);
         cfg_ff.duty_scale  <= SCALE_W'(6711);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GAIN_THRUST: cfg_ff.gain_thrust <= csr_wdata;
            REG_GAIN_ROLL:   cfg_ff.gain_roll   <= csr_wdata;
            REG_GAIN_PITCH:  cfg_ff.gain_pitch  <= csr_wdata;
            REG_GAIN_YAW:    cfg_ff.gain_yaw    <= csr_wdata;
            REG_DUTY_SCALE:  cfg_ff.duty_scale  <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   qxmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   qxmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   qxmm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .duty_scale (cfg_ff.duty_scale),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/qxmm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_front
// Takes input words, classifies armed/stopped and forms the four mixed sums.
// ----------------------------------------------------------------------------
module qxmm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [qxmm_pkg::REQ_W-1:0]  req_tdata,
   input  qxmm_pkg::qxmm_cfg_type      cfg,
   output logic                        push_valid,
   input  logic                        push_ready,
   output qxmm_pkg::qxmm_entry_type    push_entry
);
   import qxmm_pkg::*;

   logic                 valid_ff, valid_in;
   logic [PROD_W-1:0]    prod_ff [4];
   logic [3:0]           neg_ff;
   logic                 run_ff;
   logic [D_W-1:0]       d_ff;
   logic [GAIN_W-1:0]    gain [4];
   logic [CMD_W-1:0]     cmd [4];
   logic                 req_fire;
   logic signed [SUM_W-1:0] t, r, p, y;

   assign gain[0] = cfg.gain_thrust;
   assign gain[1] = cfg.gain_roll;
   assign gain[2] = cfg.gain_pitch;
   assign gain[3] = cfg.gain_yaw;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cmd[i] = req_tdata[CMD_W*i +: CMD_W];
      end
   end

   assign req_tready = !valid_ff || push_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign push_valid = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= PROD_W'(cmd_mag(cmd[i])) * PROD_W'(gain[i]);
            neg_ff[i]  <= cmd[i][CMD_W-1];
         end
         run_ff <= (req_tdata[145:144] == ARM_RUN) && !req_tdata[146];
         d_ff   <= D_W'(req_tdata[143:128]) * D_MUL + D_ADD;
      end
   end

   assign t = signed_term(neg_ff[0], prod_ff[0]);
   assign r = signed_term(neg_ff[1], prod_ff[1]);
   assign p = signed_term(neg_ff[2], prod_ff[2]);
   assign y = signed_term(neg_ff[3], prod_ff[3]);

   // X-frame sign pattern
   assign push_entry.s1  = t - r + p - y;
   assign push_entry.s2  = t + r + p + y;
   assign push_entry.s3  = t + r - p - y;
   assign push_entry.s4  = t - r - p + y;
   assign push_entry.run = run_ff;
   assign push_entry.d   = d_ff;

endmodule

// ===== rtl/qxmm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_queue
// Short first-in first-out queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module qxmm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  qxmm_pkg::qxmm_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output qxmm_pkg::qxmm_entry_type pop_entry
);
   import qxmm_pkg::*;

   qxmm_entry_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                push, pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/qxmm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_lane
// One motor: clamp, square root, motor model, divide, clamp and duty product.
// ----------------------------------------------------------------------------
module qxmm_lane (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [qxmm_pkg::SUM_W-1:0] s_in,
   input  logic [qxmm_pkg::D_W-1:0]          d_in,
   input  logic [qxmm_pkg::SCALE_W-1:0]      scale,
   output logic [qxmm_pkg::MUL_W-1:0]        prod_out
);
   import qxmm_pkg::*;

   // square root pipeline, index 0 is the clamped input
   logic [SQ_W-1:0]   bits_ff [SQRT_STEPS+1];
   logic [REM_W-1:0]  rem_ff  [SQRT_STEPS+1];
   logic [ROOT_W-1:0] root_ff [SQRT_STEPS+1];
   logic [D_W-1:0]    sd_ff   [SQRT_STEPS+1];
   logic [DLIM_W-1:0] sdl_ff  [SQRT_STEPS+1];

   logic [WSQ_W-1:0]  wsq_ff;
   logic [LIN_W-1:0]  lin_ff;
   logic [N_W-1:0]    n_ff;
   logic              npos_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [D_W-1:0]    da_ff, db_ff, dc_ff;
   logic [DLIM_W-1:0] dla_ff, dlb_ff, dlc_ff;

   // divider pipeline, index 0 is the saturation check stage
   logic [REMD_W-1:0] drem_ff [DIV_STEPS+1];
   logic [Q_W-1:0]    q_ff    [DIV_STEPS+1];
   logic [D_W-1:0]    dd_ff   [DIV_STEPS+1];
   logic              sat_ff  [DIV_STEPS+1];
   logic              dpos_ff [DIV_STEPS+1];

   logic [P_W-1:0]    p_ff, p_in, p_sum;
   logic [MUL_W-1:0]  mul_ff;
   logic              sat_now;

   always_ff @(posedge clock) begin
      if (en) begin
         bits_ff[0] <= s_in[SUM_W-1] ? '0 : s_in[SQ_W-1:0];
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         sd_ff[0]   <= d_in;
         sdl_ff[0]  <= DLIM_W'(d_in) * Q_SAT;
      end
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      logic [REM_W-1:0] rem_sh, trial;
      logic             ge;
      assign rem_sh = {rem_ff[i][REM_W-3:0], bits_ff[i][SQ_W-1 -: 2]};
      assign trial  = REM_W'({root_ff[i], 2'b01});
      assign ge     = rem_sh >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            bits_ff[i+1] <= bits_ff[i] << 2;
            rem_ff[i+1]  <= ge ? rem_sh - trial : rem_sh;
            root_ff[i+1] <= {root_ff[i][ROOT_W-2:0], ge};
            sd_ff[i+1]   <= sd_ff[i];
            sdl_ff[i+1]  <= sdl_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wsq_ff  <= WSQ_W'(root_ff[SQRT_STEPS]) * WSQ_W'(root_ff[SQRT_STEPS]);
         lin_ff  <= LIN_W'(root_ff[SQRT_STEPS]) * LIN_K;
         da_ff   <= sd_ff[SQRT_STEPS];
         dla_ff  <= sdl_ff[SQRT_STEPS];
         // w*w + 4668*16*w - 133500*256
         n_ff    <= N_W'(wsq_ff) + N_W'(lin_ff) - CONST_K;
         db_ff   <= da_ff;
         dlb_ff  <= dla_ff;
         npos_ff <= !n_ff[N_W-1] && (n_ff != '0);
         num_ff  <= n_ff[N_W-1] ? '0
                    : (NUM_W'(n_ff) << 6) + (NUM_W'(n_ff) << 5) + (NUM_W'(n_ff) << 2);
         dc_ff   <= db_ff;
         dlc_ff  <= dlb_ff;
      end
   end

   // quotient beyond the pulse ceiling is only flagged, not divided out
   assign sat_now = num_ff >= NUM_W'(dlc_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         drem_ff[0] <= sat_now ? '0 : num_ff[REMD_W-1:0];
         q_ff[0]    <= '0;
         dd_ff[0]   <= dc_ff;
         sat_ff[0]  <= sat_now;
         dpos_ff[0] <= npos_ff;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [REMD_W-1:0] dsh;
      logic              ge;
      assign dsh = REMD_W'(dd_ff[j]) << (DIV_STEPS - 1 - j);
      assign ge  = drem_ff[j] >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[j+1] <= ge ? drem_ff[j] - dsh : drem_ff[j];
            q_ff[j+1]    <= {q_ff[j][Q_W-2:0], ge};
            dd_ff[j+1]   <= dd_ff[j];
            sat_ff[j+1]  <= sat_ff[j];
            dpos_ff[j+1] <= dpos_ff[j];
         end
      end
   end

   assign p_sum = P_W'(q_ff[DIV_STEPS]) + P_OFF;

   always_comb begin
      priority if (!dpos_ff[DIV_STEPS]) begin
         p_in = P_MIN;
      end else if (sat_ff[DIV_STEPS]) begin
         p_in = P_MAX;
      end else if (p_sum < P_MIN) begin
         p_in = P_MIN;
      end else begin
         p_in = p_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         mul_ff <= MUL_W'(p_ff) * MUL_W'(scale);
      end
   end

   assign prod_out = mul_ff;

endmodule

// ===== rtl/qxmm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_back
// Four motor lanes in lockstep, valid tracking and the result register.
// ----------------------------------------------------------------------------
module qxmm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  qxmm_pkg::qxmm_entry_type    pop_entry,
   input  logic [qxmm_pkg::SCALE_W-1:0] duty_scale,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [qxmm_pkg::RSP_W-1:0]  rsp_tdata
);
   import qxmm_pkg::*;

   logic [LANE_LAT-1:0] vld_ff, run_ff;
   logic                out_valid_ff;
   logic [RSP_W-1:0]    out_data_ff, out_data_in;
   logic                adv;
   logic [MUL_W-1:0]    prod [4];
   logic signed [SUM_W-1:0] s [4];
   logic [STOP_W-1:0]   stop_full;
   logic [DUTY_W-1:0]   stop_duty;
   logic [DUTY_W-1:0]   duty [4];

   // whole pipeline moves when the result register is free or being taken
   assign adv       = !out_valid_ff || rsp_tready;
   assign pop_ready = adv;

   assign s[0] = pop_entry.s1;
   assign s[1] = pop_entry.s2;
   assign s[2] = pop_entry.s3;
   assign s[3] = pop_entry.s4;

   for (genvar m = 0; m < 4; m++) begin : g_lane
      qxmm_lane u_lane (
         .clock    (clock),
         .en       (adv),
         .s_in     (s[m]),
         .d_in     (pop_entry.d),
         .scale    (duty_scale),
         .prod_out (prod[m])
      );
   end

   assign stop_full = STOP_US * STOP_W'(duty_scale);
   assign stop_duty = (|stop_full[STOP_W-1:24]) ? DUTY_MAX : stop_full[23:8];

   always_comb begin
      for (int m = 0; m < 4; m++) begin
         duty[m] = (|prod[m][MUL_W-1:32]) ? DUTY_MAX : prod[m][31:16];
      end
      out_data_in = '0;
      for (int m = 0; m < 4; m++) begin
         out_data_in[DUTY_W*m +: DUTY_W] = run_ff[LANE_LAT-1] ? duty[m] : stop_duty;
      end
      out_data_in[64] = run_ff[LANE_LAT-1];
      out_data_in[65] = !run_ff[LANE_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LANE_LAT-2:0], pop_valid};
         out_valid_ff <= vld_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         run_ff      <= {run_ff[LANE_LAT-2:0], pop_entry.run};
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== rtl/qxmm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_checker
// Port-level checks of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
module qxmm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [qxmm_pkg::RSP_W-1:0]  rsp_tdata
);
   import qxmm_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_status_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[64] != rsp_tdata[65]))
      else $error("running and clear flags not complementary");

   a_stop_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65]) |->
         (rsp_tdata[15:0] == rsp_tdata[31:16]) && (rsp_tdata[31:16] == rsp_tdata[47:32])
         && (rsp_tdata[47:32] == rsp_tdata[63:48]))
      else $error("stopped word with unequal duties");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

endmodule

bind quad_x_motor_mixer_unit qxmm_checker u_qxmm_checker (.*);
